### sv/bpbtb_pkg.sv
// ----------------------------------------------------------------------------
// bpbtb_pkg
// Shared types and constants of the branch predictor: operation and mode
// codes, counter encodings and the control state type.
// ----------------------------------------------------------------------------
package bpbtb_pkg;

  localparam int PC_W   = 64;
  localparam int OP_W   = 2;
  localparam int MODE_W = 2;
  localparam int CNT_W  = 2;

  localparam logic [OP_W-1:0] OP_PREDICT = 2'd0;
  localparam logic [OP_W-1:0] OP_UPDATE  = 2'd1;
  localparam logic [OP_W-1:0] OP_WRITE   = 2'd2;

  localparam logic [MODE_W-1:0] MODE_LOCAL  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_GLOBAL = 2'd1;
  localparam logic [MODE_W-1:0] MODE_GSHARE = 2'd2;

  localparam logic [CNT_W-1:0] CNT_RESET = 2'd2;
  localparam logic [CNT_W-1:0] CNT_MAX   = 2'd3;
  localparam logic [CNT_W-1:0] CNT_MIN   = 2'd0;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS
  } bpbtb_state_t;

endpackage

### sv/bpbtb_ram.sv
// ----------------------------------------------------------------------------
// bpbtb_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module bpbtb_ram #(
  parameter int ADDR_W = 10,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/branch_predictor_btb_bht.sv
// ----------------------------------------------------------------------------
// branch_predictor_btb_bht
// Branch prediction unit: direct-mapped target buffer plus a table of 2-bit
// saturating direction counters, indexed by pc, global history or gshare.
// ----------------------------------------------------------------------------
// In a predict or direction update transaction the accepting edge issues
// the read of both memories and the following cycle uses the read data,
// writing the counter back for an update. A predict result shows on the
// out_ ports with out_valid for one cycle right after that, and must be
// taken then since the receiver cannot stall; the next start can be
// accepted in that same cycle. A target write is done at the accepting
// edge and leaves the unit idle. After reset a clearing pass over every
// index of the larger table presets every counter to weakly taken and
// invalidates every target entry, with busy high; cfg writes are taken at
// any time.
module branch_predictor_btb_bht #(
  parameter int TARGET_INDEX_BITS  = 10,
  parameter int COUNTER_INDEX_BITS = 15
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [bpbtb_pkg::OP_W-1:0]     in_operation,
  input  logic [bpbtb_pkg::PC_W-1:0]     in_pc,
  input  logic                           in_taken,
  input  logic [bpbtb_pkg::PC_W-1:0]     in_new_target,
  output logic                           out_valid,
  output logic                           out_target_hit,
  output logic [bpbtb_pkg::PC_W-1:0]     out_predicted_target,
  output logic                           out_predict_taken,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bpbtb_pkg::MODE_W-1:0]   cfg_data
);

  import bpbtb_pkg::*;

  localparam int TIB   = TARGET_INDEX_BITS;
  localparam int CIB   = COUNTER_INDEX_BITS;
  localparam int TAG_W = PC_W - TIB - 2;
  localparam int BTB_W = 1 + TAG_W + PC_W;
  localparam int CLR_W = (TIB > CIB) ? TIB : CIB;

  bpbtb_state_t state_r, state_nxt;

  logic [MODE_W-1:0] mode_r;
  logic [CIB-1:0]    hist_r, hist_nxt;
  logic [CLR_W-1:0]  clr_cnt_r;

  logic [OP_W-1:0]   op_r;
  logic              taken_r;
  logic [TAG_W-1:0]  tag_r;
  logic [CIB-1:0]    ci_r;

  logic              accept;
  logic [TIB-1:0]    btb_idx;
  logic [TAG_W-1:0]  in_tag;
  logic [CIB-1:0]    local_idx;
  logic [CIB-1:0]    ci;

  logic              btb_we;
  logic [TIB-1:0]    btb_waddr;
  logic [BTB_W-1:0]  btb_wdata;
  logic [BTB_W-1:0]  btb_rdata;

  logic              cnt_we;
  logic [CIB-1:0]    cnt_waddr;
  logic [CNT_W-1:0]  cnt_wdata;
  logic [CNT_W-1:0]  cnt_rdata;
  logic [CNT_W-1:0]  cnt_step;

  logic              hit;
  logic              out_valid_r, out_valid_nxt;
  logic              out_hit_r;
  logic [PC_W-1:0]   out_target_r;
  logic              out_taken_r;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  assign btb_idx   = in_pc[TIB+1:2];
  assign in_tag    = in_pc[PC_W-1:TIB+2];
  assign local_idx = in_pc[CIB+1:2];

  // counter index from the mode; the unused code behaves as gshare
  always_comb begin
    unique case (mode_r)
      MODE_LOCAL:  ci = local_idx;
      MODE_GLOBAL: ci = hist_r;
      default:     ci = local_idx ^ hist_r;
    endcase
  end

  assign hit = btb_rdata[BTB_W-1] && (btb_rdata[BTB_W-2:PC_W] == tag_r);

  always_comb begin
    if (taken_r) begin
      cnt_step = (cnt_rdata == CNT_MAX) ? CNT_MAX : cnt_rdata + 2'd1;
    end else begin
      cnt_step = (cnt_rdata == CNT_MIN) ? CNT_MIN : cnt_rdata - 2'd1;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    hist_nxt      = hist_r;
    out_valid_nxt = 1'b0;
    btb_we        = 1'b0;
    btb_waddr     = btb_idx;
    btb_wdata     = {1'b1, in_tag, in_new_target};
    cnt_we        = 1'b0;
    cnt_waddr     = ci_r;
    cnt_wdata     = cnt_step;
    unique case (state_r)
      ST_CLEAR: begin
        btb_we    = 1'b1;
        btb_waddr = clr_cnt_r[TIB-1:0];
        btb_wdata = '0;
        cnt_we    = 1'b1;
        cnt_waddr = clr_cnt_r[CIB-1:0];
        cnt_wdata = CNT_RESET;
        if (clr_cnt_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_operation == OP_PREDICT || in_operation == OP_UPDATE) begin
            state_nxt = ST_ACCESS;
          end
          btb_we = (in_operation == OP_WRITE);
        end
      end
      ST_ACCESS: begin
        state_nxt = ST_IDLE;
        if (op_r == OP_PREDICT) begin
          out_valid_nxt = 1'b1;
        end
        if (op_r == OP_UPDATE) begin
          cnt_we = 1'b1;
          if (mode_r != MODE_LOCAL) begin
            hist_nxt = {taken_r, hist_r[CIB-1:1]};
          end
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      mode_r      <= MODE_GSHARE;
      hist_r      <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hist_r      <= hist_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        mode_r <= cfg_data;
      end
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  // transaction fields held for the access cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_operation;
      taken_r <= in_taken;
      tag_r   <= in_tag;
      ci_r    <= ci;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_nxt) begin
      out_hit_r    <= hit;
      out_target_r <= hit ? btb_rdata[PC_W-1:0] : '0;
      out_taken_r  <= cnt_rdata[1];
    end
  end

  assign out_valid            = out_valid_r;
  assign out_target_hit       = out_hit_r;
  assign out_predicted_target = out_target_r;
  assign out_predict_taken    = out_taken_r;

  // valid bit, tag and target in one word
  bpbtb_ram #(
    .ADDR_W (TIB),
    .DATA_W (BTB_W)
  ) u_btb_ram (
    .clk   (clk),
    .we    (btb_we),
    .waddr (btb_waddr),
    .wdata (btb_wdata),
    .re    (accept),
    .raddr (btb_idx),
    .rdata (btb_rdata)
  );

  bpbtb_ram #(
    .ADDR_W (CIB),
    .DATA_W (CNT_W)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (accept),
    .raddr (ci),
    .rdata (cnt_rdata)
  );

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for branch_predictor_btb_bht. Drives predict,
// direction update and target write transactions through the start/busy
// port, mirrors the target buffer, counter table and history in a local
// predictor, and checks every out_valid strobe against the oldest
// prediction still due. Directed tests cover reset defaults, hits, aliasing,
// counter saturation, all modes and the ignored opcode; random traffic
// then runs in every mode, with sender gaps in all but the gshare phase.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bpbtb_pkg::*;

  localparam int TGT_BITS = 10;
  localparam int CTR_BITS = 15;
  localparam int TAG_W    = PC_W - TGT_BITS - 2;
  localparam int WATCHDOG_LIMIT = 140000;
  localparam int DRAIN_CYCLES   = 4;
  localparam int POOL_SIZE      = 40;
  localparam int ALIAS_BASE     = 32;
  localparam int PHASE_ITEMS    = 390;

  localparam logic [OP_W-1:0]   OP_IGNORED  = 2'd3;
  localparam logic [MODE_W-1:0] MODE_ALT_GS = 2'd3;

  localparam logic [PC_W-1:0] PC_A = 64'h0000_7f3c_0040_1a34;
  localparam logic [PC_W-1:0] PC_B = 64'h0000_0000_0002_5678;

  typedef struct packed {
    logic            hit;
    logic [PC_W-1:0] target;
    logic            taken;
  } prediction_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [OP_W-1:0]   in_operation;
  logic [PC_W-1:0]   in_pc;
  logic              in_taken;
  logic [PC_W-1:0]   in_new_target;
  logic              out_valid;
  logic              out_target_hit;
  logic [PC_W-1:0]   out_predicted_target;
  logic              out_predict_taken;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [MODE_W-1:0] cfg_data;

  // predictor state
  logic [TAG_W-1:0] btb_tag    [0:(1<<TGT_BITS)-1];
  logic [PC_W-1:0]  btb_target [0:(1<<TGT_BITS)-1];
  bit               btb_valid  [0:(1<<TGT_BITS)-1];
  logic [CNT_W-1:0] dir_ctr    [0:(1<<CTR_BITS)-1];
  logic [CTR_BITS-1:0] ghist;
  logic [MODE_W-1:0]   cur_mode;

  prediction_t predictions_due[$];
  int mismatch_count = 0;
  int stall_cycles = 0;

  branch_predictor_btb_bht #(
    .TARGET_INDEX_BITS  (TGT_BITS),
    .COUNTER_INDEX_BITS (CTR_BITS)
  ) DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_operation         (in_operation),
    .in_pc                (in_pc),
    .in_taken             (in_taken),
    .in_new_target        (in_new_target),
    .out_valid            (out_valid),
    .out_target_hit       (out_target_hit),
    .out_predicted_target (out_predicted_target),
    .out_predict_taken    (out_predict_taken),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_data             (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [CTR_BITS-1:0] counter_slot(logic [PC_W-1:0] pc);
    logic [CTR_BITS-1:0] by_pc;
    by_pc = pc[CTR_BITS+1:2];
    case (cur_mode)
      MODE_LOCAL:  return by_pc;
      MODE_GLOBAL: return ghist;
      default:     return by_pc ^ ghist;
    endcase
  endfunction

  task automatic clear_predictor();
    foreach (btb_valid[i]) btb_valid[i] = 1'b0;
    foreach (dir_ctr[i]) dir_ctr[i] = CNT_RESET;
    ghist = '0;
    cur_mode = MODE_GSHARE;
  endtask

  // advances the mirrored state by one accepted transaction
  task automatic apply_branch_op(input logic [OP_W-1:0] op, input logic [PC_W-1:0] pc,
                                 input logic tk, input logic [PC_W-1:0] tgt);
    logic [TGT_BITS-1:0] slot;
    logic [TAG_W-1:0]    tag;
    logic [CTR_BITS-1:0] ci;
    prediction_t         p;
    slot = pc[TGT_BITS+1:2];
    tag  = pc[PC_W-1:TGT_BITS+2];
    ci   = counter_slot(pc);
    case (op)
      OP_PREDICT: begin
        p.hit    = btb_valid[slot] && (btb_tag[slot] == tag);
        p.target = p.hit ? btb_target[slot] : '0;
        p.taken  = dir_ctr[ci][1];
        predictions_due.push_back(p);
      end
      OP_UPDATE: begin
        if (tk && dir_ctr[ci] != CNT_MAX) begin
          dir_ctr[ci] = dir_ctr[ci] + 1'b1;
        end else if (!tk && dir_ctr[ci] != CNT_MIN) begin
          dir_ctr[ci] = dir_ctr[ci] - 1'b1;
        end
        if (cur_mode != MODE_LOCAL) begin
          ghist = {tk, ghist[CTR_BITS-1:1]};
        end
      end
      OP_WRITE: begin
        btb_tag[slot]    = tag;
        btb_target[slot] = tgt;
        btb_valid[slot]  = 1'b1;
      end
      default: ;
    endcase
  endtask

  // start is left high after acceptance; whatever runs next drives it at the next negedge
  task automatic send_item(input logic [OP_W-1:0] op, input logic [PC_W-1:0] pc,
                           input logic tk, input logic [PC_W-1:0] tgt);
    @(negedge clk);
    start         <= 1'b1;
    in_operation  <= op;
    in_pc         <= pc;
    in_taken      <= tk;
    in_new_target <= tgt;
    do @(posedge clk); while (busy !== 1'b0);
    apply_branch_op(op, pc, tk, tgt);
  endtask

  task automatic idle_for(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // wait for every prediction to come back, then let trailing updates finish
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (predictions_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_mode(input logic [MODE_W-1:0] m);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cur_mode = m;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    prediction_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (predictions_due.size() == 0) begin
        $display("%0t: unexpected result hit=%0b target=%h taken=%0b", $time,
                 out_target_hit, out_predicted_target, out_predict_taken);
        mismatch_count++;
      end else begin
        want = predictions_due.pop_front();
        if (out_target_hit !== want.hit) begin
          $display("%0t: target_hit expected %0b actual %0b", $time,
                   want.hit, out_target_hit);
          mismatch_count++;
        end
        if (out_predicted_target !== want.target) begin
          $display("%0t: predicted_target expected %h actual %h", $time,
                   want.target, out_predicted_target);
          mismatch_count++;
        end
        if (out_predict_taken !== want.taken) begin
          $display("%0t: predict_taken expected %0b actual %0b", $time,
                   want.taken, out_predict_taken);
          mismatch_count++;
        end
      end
    end
  end

  // counts cycles with no transaction of any kind
  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1 ||
        (cfg_valid === 1'b1 && cfg_ready === 1'b1)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic test_reset_defaults();
    send_item(OP_PREDICT, '0, 1'b0, '0);
    send_item(OP_PREDICT, '1, 1'b1, '1);
  endtask

  task automatic test_target_buffer();
    send_item(OP_WRITE, PC_A, 1'b0, '1);
    send_item(OP_PREDICT, PC_A, 1'b0, '0);
    // same index, tag differs only in the top bit
    send_item(OP_PREDICT, PC_A ^ (64'h1 << 63), 1'b0, '0);
    send_item(OP_WRITE, '1, 1'b1, '0);
    send_item(OP_PREDICT, '1, 1'b0, '0);
  endtask

  task automatic test_ignored_op();
    send_item(OP_IGNORED, PC_A, 1'b1, 64'h5555_aaaa_5555_aaaa);
    send_item(OP_PREDICT, PC_A, 1'b0, '0);
  endtask

  task automatic test_counter_saturation();
    write_mode(MODE_LOCAL);
    repeat (2) send_item(OP_UPDATE, PC_B, 1'b1, '0);
    send_item(OP_PREDICT, PC_B, 1'b0, '0);
    repeat (3) send_item(OP_UPDATE, PC_B, 1'b0, '0);
    send_item(OP_PREDICT, PC_B, 1'b0, '0);
  endtask

  task automatic test_history_modes();
    write_mode(MODE_GLOBAL);
    send_item(OP_UPDATE, PC_B, 1'b1, '0);
    send_item(OP_PREDICT, PC_B, 1'b0, '0);
    write_mode(MODE_ALT_GS);
    send_item(OP_UPDATE, PC_B, 1'b0, '0);
    send_item(OP_PREDICT, PC_B, 1'b0, '0);
  endtask

  task automatic test_random_traffic();
    logic [MODE_W-1:0] phase_mode [4];
    logic [PC_W-1:0]   pool [POOL_SIZE];
    logic [OP_W-1:0]   op;
    logic [PC_W-1:0]   pc;
    int                r;
    phase_mode = '{MODE_LOCAL, MODE_GLOBAL, MODE_GSHARE, MODE_ALT_GS};
    // a small set of branches so targets hit and counters move; the tail aliases the head
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool[i] = {$urandom, $urandom};
      if (i >= ALIAS_BASE) pool[i][TGT_BITS+1:0] = pool[i-ALIAS_BASE][TGT_BITS+1:0];
    end
    for (int ph = 0; ph < 4; ph++) begin
      write_mode(phase_mode[ph]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 0 && n == PHASE_ITEMS / 2) drain();
        r = $urandom_range(99);
        if (r < 45) op = OP_PREDICT;
        else if (r < 80) op = OP_UPDATE;
        else if (r < 96) op = OP_WRITE;
        else op = OP_IGNORED;
        pc = ($urandom_range(99) < 80) ? pool[$urandom_range(POOL_SIZE-1)]
                                        : {$urandom, $urandom};
        send_item(op, pc, 1'($urandom_range(1)), {$urandom, $urandom});
        // the gshare phase runs back to back
        if (ph != 2 && $urandom_range(99) < 23) idle_for($urandom_range(1, 3));
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_operation   = OP_PREDICT;
    in_pc          = '0;
    in_taken       = 1'b0;
    in_new_target  = '0;
    cfg_valid      = 1'b0;
    cfg_data       = MODE_GSHARE;
    clear_predictor();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_target_buffer();
    test_ignored_op();
    test_counter_saturation();
    test_history_modes();
    test_random_traffic();

    drain();
    repeat (8) @(posedge clk);
    if (predictions_due.size() != 0) begin
      $display("%0t: %0d predictions never returned", $time, predictions_due.size());
    end
    if (mismatch_count == 0 && predictions_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
